### rtl/rank_prefix_overlap_counter_macros.svh
// assertion macros used by the checker module
`ifndef RANK_PREFIX_OVERLAP_COUNTER_MACROS_SVH
`define RANK_PREFIX_OVERLAP_COUNTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RPOC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpoc check failed");

// next-cycle implication, disabled while in reset
`define RPOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpoc check failed");

`endif

### rtl/rpoc_pkg.sv
`timescale 1ns / 1ps

package rpoc_pkg;

    // sizes of the rank tables and of the counts
    localparam int ADDR_W       = 12;
    localparam int CNT_W        = 13;
    localparam int MAX_ELEMENTS = 4096;
    localparam int MARK_W       = 2;

    localparam logic [CNT_W-1:0] MAX_COUNT           = CNT_W'(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] ELEMENT_COUNT_RESET = CNT_W'(4096);

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_WALK_TBL,
        ST_WALK_MRK,
        ST_WALK_UPD,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic clear_step;
        logic walk_start;
        logic walk_sel_b;
        logic walk_to_zero;
        logic tbl_read;
        logic mark_read;
        logic mark_write;
        logic table_write;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic range_err;
        logic walk_done;
        logic walk_b;
        logic clear_done;
        logic out_busy;
    } status_t;

endpackage

### rtl/rpoc_in_if.sv
`timescale 1ns / 1ps

interface rpoc_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  operation;
    logic [rpoc_pkg::ADDR_W-1:0] rank_position;
    logic [rpoc_pkg::ADDR_W-1:0] element_id;
    logic [rpoc_pkg::ADDR_W-1:0] prefix_a_last;
    logic [rpoc_pkg::ADDR_W-1:0] prefix_b_last;

    modport source (
        output valid, operation, rank_position, element_id, prefix_a_last, prefix_b_last,
        input  ready
    );

    modport sink (
        input  valid, operation, rank_position, element_id, prefix_a_last, prefix_b_last,
        output ready
    );
endinterface

### rtl/rpoc_out_if.sv
`timescale 1ns / 1ps

interface rpoc_out_if;
    logic                       valid;
    logic                       ready;
    logic [rpoc_pkg::CNT_W-1:0] overlap_count;
    logic                       range_error;

    modport source (
        output valid, overlap_count, range_error,
        input  ready
    );

    modport sink (
        input  valid, overlap_count, range_error,
        output ready
    );
endinterface

### rtl/rpoc_ram.sv
`timescale 1ns / 1ps

module rpoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/rpoc_ctrl.sv
`timescale 1ns / 1ps

module rpoc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rpoc_pkg::status_t status,
    output rpoc_pkg::cmd_t    cmd
);

    rpoc_pkg::state_t state_reg;
    rpoc_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpoc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            rpoc_pkg::ST_CLEAR:
            begin
                // wipe the membership marks after reset
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = rpoc_pkg::ST_IDLE;
                end
            end
            rpoc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = rpoc_pkg::ST_DECODE;
                end
            end
            rpoc_pkg::ST_DECODE:
            begin
                case (status.op)
                    rpoc_pkg::OP_LOAD_A,
                    rpoc_pkg::OP_LOAD_B:
                    begin
                        // a load first shrinks both prefixes to empty
                        cmd.walk_start   = 1'b1;
                        cmd.walk_to_zero = 1'b1;
                        state_next       = rpoc_pkg::ST_WALK_TBL;
                    end
                    rpoc_pkg::OP_QUERY:
                    begin
                        if (status.range_err)
                        begin
                            state_next = rpoc_pkg::ST_EMIT;
                        end
                        else
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = rpoc_pkg::ST_WALK_TBL;
                        end
                    end
                    default:
                    begin
                        state_next = rpoc_pkg::ST_IDLE;
                    end
                endcase
            end
            rpoc_pkg::ST_WALK_TBL:
            begin
                if (status.walk_done)
                begin
                    if (!status.walk_b)
                    begin
                        // ordering a finished, move ordering b
                        cmd.walk_start   = 1'b1;
                        cmd.walk_sel_b   = 1'b1;
                        cmd.walk_to_zero = (status.op != rpoc_pkg::OP_QUERY);
                    end
                    else if (status.op == rpoc_pkg::OP_QUERY)
                    begin
                        state_next = rpoc_pkg::ST_EMIT;
                    end
                    else
                    begin
                        cmd.table_write = 1'b1;
                        state_next      = rpoc_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cmd.tbl_read = 1'b1;
                    state_next   = rpoc_pkg::ST_WALK_MRK;
                end
            end
            rpoc_pkg::ST_WALK_MRK:
            begin
                cmd.mark_read = 1'b1;
                state_next    = rpoc_pkg::ST_WALK_UPD;
            end
            rpoc_pkg::ST_WALK_UPD:
            begin
                cmd.mark_write = 1'b1;
                state_next     = rpoc_pkg::ST_WALK_TBL;
            end
            rpoc_pkg::ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = rpoc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rpoc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/rpoc_dpath.sv
`timescale 1ns / 1ps

module rpoc_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [rpoc_pkg::CNT_W-1:0]  cfg_write_data,
    input  logic [1:0]                  in_operation,
    input  logic [rpoc_pkg::ADDR_W-1:0] in_rank_position,
    input  logic [rpoc_pkg::ADDR_W-1:0] in_element_id,
    input  logic [rpoc_pkg::ADDR_W-1:0] in_prefix_a_last,
    input  logic [rpoc_pkg::ADDR_W-1:0] in_prefix_b_last,
    input  rpoc_pkg::cmd_t              cmd,
    output rpoc_pkg::status_t           status,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rpoc_pkg::CNT_W-1:0]  out_overlap_count,
    output logic                        out_range_error
);

    logic [rpoc_pkg::CNT_W-1:0]  element_count_reg;
    rpoc_pkg::op_t               op_reg;
    logic [rpoc_pkg::ADDR_W-1:0] pos_reg;
    logic [rpoc_pkg::ADDR_W-1:0] id_reg;
    logic [rpoc_pkg::ADDR_W-1:0] ia_reg;
    logic [rpoc_pkg::ADDR_W-1:0] jb_reg;

    logic [rpoc_pkg::CNT_W-1:0]  len_a_reg;
    logic [rpoc_pkg::CNT_W-1:0]  len_b_reg;
    logic [rpoc_pkg::CNT_W-1:0]  walk_k_reg;
    logic [rpoc_pkg::CNT_W-1:0]  walk_end_reg;
    logic                        walk_grow_reg;
    logic                        walk_b_reg;
    logic [rpoc_pkg::ADDR_W-1:0] walk_id_reg;
    logic [rpoc_pkg::CNT_W-1:0]  count_reg;
    logic [rpoc_pkg::CNT_W-1:0]  count_next;
    logic [rpoc_pkg::ADDR_W-1:0] clr_reg;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [rpoc_pkg::CNT_W-1:0]  out_count_reg;
    logic                        out_error_reg;

    logic [rpoc_pkg::CNT_W-1:0]  limit;
    logic                        range_err;
    logic [rpoc_pkg::CNT_W-1:0]  cur_len;
    logic [rpoc_pkg::CNT_W-1:0]  target;
    logic                        grow;

    logic [rpoc_pkg::ADDR_W-1:0] tbl_a_rdata;
    logic [rpoc_pkg::ADDR_W-1:0] tbl_b_rdata;
    logic [rpoc_pkg::ADDR_W-1:0] walk_tbl_id;
    logic [rpoc_pkg::MARK_W-1:0] mark_rdata;
    logic [rpoc_pkg::MARK_W-1:0] mark_new;
    logic                        own_old;
    logic                        other_old;
    logic                        mark_we;
    logic [rpoc_pkg::ADDR_W-1:0] mark_waddr;
    logic [rpoc_pkg::MARK_W-1:0] mark_wdata;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= rpoc_pkg::ELEMENT_COUNT_RESET;
        end
        else if (cfg_write_en)
        begin
            element_count_reg <= cfg_write_data;
        end
    end

    // captured input beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= rpoc_pkg::op_t'(in_operation);
            pos_reg <= in_rank_position;
            id_reg  <= in_element_id;
            ia_reg  <= in_prefix_a_last;
            jb_reg  <= in_prefix_b_last;
        end
    end

    // query range check against min(element_count, table depth)
    always_comb
    begin
        limit     = (element_count_reg < rpoc_pkg::MAX_COUNT) ?
                    element_count_reg : rpoc_pkg::MAX_COUNT;
        range_err = ({1'b0, ia_reg} >= limit) || ({1'b0, jb_reg} >= limit);
    end

    // walk bounds for the selected ordering
    always_comb
    begin
        cur_len = cmd.walk_sel_b ? len_b_reg : len_a_reg;
        if (cmd.walk_to_zero)
        begin
            target = '0;
        end
        else if (cmd.walk_sel_b)
        begin
            target = {1'b0, jb_reg} + rpoc_pkg::CNT_W'(1);
        end
        else
        begin
            target = {1'b0, ia_reg} + rpoc_pkg::CNT_W'(1);
        end
        grow = (cur_len < target);
    end

    // membership word update: own bit follows the walk direction
    always_comb
    begin
        own_old           = mark_rdata[walk_b_reg];
        other_old         = mark_rdata[!walk_b_reg];
        mark_new          = mark_rdata;
        mark_new[walk_b_reg] = walk_grow_reg;
        count_next        = count_reg;
        if (cmd.mark_write && other_old && (own_old != walk_grow_reg))
        begin
            if (walk_grow_reg)
            begin
                count_next = count_reg + rpoc_pkg::CNT_W'(1);
            end
            else
            begin
                count_next = count_reg - rpoc_pkg::CNT_W'(1);
            end
        end
    end

    // prefix lengths, walk pointer and running overlap count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg     <= '0;
            len_b_reg     <= '0;
            walk_k_reg    <= '0;
            walk_end_reg  <= '0;
            walk_grow_reg <= 1'b0;
            walk_b_reg    <= 1'b0;
            count_reg     <= '0;
            clr_reg       <= '0;
        end
        else
        begin
            if (cmd.walk_start)
            begin
                walk_b_reg    <= cmd.walk_sel_b;
                walk_grow_reg <= grow;
                walk_k_reg    <= grow ? cur_len : target;
                walk_end_reg  <= grow ? target : cur_len;
                if (cmd.walk_sel_b)
                begin
                    len_b_reg <= target;
                end
                else
                begin
                    len_a_reg <= target;
                end
            end
            else if (cmd.mark_write)
            begin
                walk_k_reg <= walk_k_reg + rpoc_pkg::CNT_W'(1);
            end
            count_reg <= count_next;
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + rpoc_pkg::ADDR_W'(1);
            end
        end
    end

    // element id of the rank entry being walked
    assign walk_tbl_id = walk_b_reg ? tbl_b_rdata : tbl_a_rdata;

    always_ff @(posedge clk)
    begin
        if (cmd.mark_read)
        begin
            walk_id_reg <= walk_tbl_id;
        end
    end

    // rank tables
    rpoc_ram #(
        .WIDTH (rpoc_pkg::ADDR_W),
        .DEPTH (rpoc_pkg::MAX_ELEMENTS)
    ) u_tbl_a (
        .clk   (clk),
        .we    (cmd.table_write && (op_reg == rpoc_pkg::OP_LOAD_A)),
        .waddr (pos_reg),
        .wdata (id_reg),
        .re    (cmd.tbl_read),
        .raddr (walk_k_reg[rpoc_pkg::ADDR_W-1:0]),
        .rdata (tbl_a_rdata)
    );

    rpoc_ram #(
        .WIDTH (rpoc_pkg::ADDR_W),
        .DEPTH (rpoc_pkg::MAX_ELEMENTS)
    ) u_tbl_b (
        .clk   (clk),
        .we    (cmd.table_write && (op_reg == rpoc_pkg::OP_LOAD_B)),
        .waddr (pos_reg),
        .wdata (id_reg),
        .re    (cmd.tbl_read),
        .raddr (walk_k_reg[rpoc_pkg::ADDR_W-1:0]),
        .rdata (tbl_b_rdata)
    );

    // membership marks, bit 0 for a and bit 1 for b, one word per element
    assign mark_we    = cmd.clear_step || cmd.mark_write;
    assign mark_waddr = cmd.clear_step ? clr_reg : walk_id_reg;
    assign mark_wdata = cmd.clear_step ? '0 : mark_new;

    rpoc_ram #(
        .WIDTH (rpoc_pkg::MARK_W),
        .DEPTH (rpoc_pkg::MAX_ELEMENTS)
    ) u_marks (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (cmd.mark_read),
        .raddr (walk_tbl_id),
        .rdata (mark_rdata)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_count_reg <= range_err ? '0 : count_reg;
            out_error_reg <= range_err;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_overlap_count = out_count_reg;
    assign out_range_error   = out_error_reg;

    // status back to the controller
    always_comb
    begin
        status.op         = op_reg;
        status.range_err  = range_err;
        status.walk_done  = (walk_k_reg == walk_end_reg);
        status.walk_b     = walk_b_reg;
        status.clear_done = (clr_reg == '1);
        status.out_busy   = out_valid_reg && !out_ready;
    end

endmodule

### rtl/rank_prefix_overlap_counter.sv
// Overlap counter for prefixes of two rank orderings A and B. After reset the block clears
// its membership memory and takes no beat during that pass. A query within range moves
// each prefix from its previous length to the new one, walking the rank entries between
// them in A and then in B; each entry takes the table read, the membership read and the
// membership write-back, done one entry at a time. A query out of range skips the walk.
// A load first shrinks both prefixes to empty and then writes its table entry, so loads
// issued before any query have no entries to walk.
// One item is worked on at a time; a finished result waits in an output register while
// the next beat is accepted.
`timescale 1ns / 1ps

module rank_prefix_overlap_counter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [rpoc_pkg::CNT_W-1:0] cfg_write_data,
    rpoc_in_if.sink                    in_ch,
    rpoc_out_if.source                 out_ch
);

    rpoc_pkg::cmd_t    cmd;
    rpoc_pkg::status_t status;
    logic              in_ready;

    // sequencer
    rpoc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign in_ch.ready = in_ready;

    // tables, marks, counters and result register
    rpoc_dpath u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .in_operation      (in_ch.operation),
        .in_rank_position  (in_ch.rank_position),
        .in_element_id     (in_ch.element_id),
        .in_prefix_a_last  (in_ch.prefix_a_last),
        .in_prefix_b_last  (in_ch.prefix_b_last),
        .cmd               (cmd),
        .status            (status),
        .out_valid         (out_ch.valid),
        .out_ready         (out_ch.ready),
        .out_overlap_count (out_ch.overlap_count),
        .out_range_error   (out_ch.range_error)
    );

endmodule

### rtl/rpoc_checker.sv
`timescale 1ns / 1ps
`include "rank_prefix_overlap_counter_macros.svh"

module rpoc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [rpoc_pkg::CNT_W-1:0] out_overlap_count,
    input logic                       out_range_error
);

    // an error result always carries a zero count
    `RPOC_ASSERT_NOW(a_err_count_zero, clk, rst_n, out_valid && out_range_error, out_overlap_count == '0)

    // a count never exceeds the table depth
    `RPOC_ASSERT_NOW(a_count_bound, clk, rst_n, out_valid, out_overlap_count <= rpoc_pkg::MAX_COUNT)

    // one item at a time: no new beat right after an accepted one
    `RPOC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

    // a stalled result beat holds
    `RPOC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_overlap_count) && $stable(out_range_error))

endmodule

bind rank_prefix_overlap_counter rpoc_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_overlap_count (out_ch.overlap_count),
    .out_range_error   (out_ch.range_error)
);
